@@ src/rdct_pkg.sv @@
// ----------------------------------------------------------------------------
// rdct_pkg
// Shared types, character codes and pattern tables for the token redactor.
// ----------------------------------------------------------------------------
package rdct_pkg;

  localparam int unsigned KEY_PATTERNS   = 12;
  localparam int unsigned VALUE_PATTERNS = 6;
  localparam int unsigned KEY_W          = 11;
  localparam int unsigned VAL_W          = 10;
  localparam int unsigned JOBQ_DEPTH     = 2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // patterns right-aligned: first character in the highest used byte
  localparam logic [8*KEY_W-1:0] KEY_PAT [KEY_PATTERNS] = '{
    "secret", "api_key", "apikey", "api-key", "token", "password",
    "passwd", "credential", "auth", {"private", "_key"}, {"access", "_key"},
    {"session", "_id"}
  };
  localparam int KEY_LEN [KEY_PATTERNS] = '{6, 7, 6, 7, 5, 8, 6, 10, 4, 11, 10, 10};

  localparam logic [8*VAL_W-1:0] VAL_PAT [VALUE_PATTERNS] = '{
    "-----begin", "bearer", "sk-", "ghp_", "xox", {"aws", "_secret"}
  };
  localparam int VAL_LEN [VALUE_PATTERNS] = '{10, 6, 3, 4, 3, 10};

  typedef enum logic [1:0] {
    JM_PLAIN,
    JM_KEYRED,
    JM_MARK,
    JM_OVF
  } job_mode_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DATA,
    BK_EQ,
    BK_MARK,
    BK_SEP
  } back_state_e;

  typedef struct packed {
    job_mode_e  mode;
    logic       has_sep;
    logic [7:0] sep_byte;
    logic       last;
    logic       bank;
  } job_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] data;
  } mem_wr_t;

  function automatic logic [KEY_W-1:0] key_mask(input int p, input logic [7:0] c);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int j = 0; j < KEY_W; j++) begin
      if (j < KEY_LEN[p]) begin
        m[j] = (KEY_PAT[p][8*(KEY_LEN[p]-1-j) +: 8] == c);
      end
    end
    return m;
  endfunction

  function automatic logic [VAL_W-1:0] val_mask(input int p, input logic [7:0] c);
    logic [VAL_W-1:0] m;
    m = '0;
    for (int j = 0; j < VAL_W; j++) begin
      if (j < VAL_LEN[p]) begin
        m[j] = (VAL_PAT[p][8*(VAL_LEN[p]-1-j) +: 8] == c);
      end
    end
    return m;
  endfunction

  function automatic back_state_e after_bytes(input job_mode_e mode, input logic has_sep);
    back_state_e s;
    unique case (mode)
      JM_PLAIN:  s = has_sep ? BK_SEP : BK_IDLE;
      JM_KEYRED: s = BK_EQ;
      JM_MARK:   s = BK_MARK;
      JM_OVF:    s = BK_MARK;
      default:   s = BK_IDLE;
    endcase
    return s;
  endfunction

endpackage

@@ src/rdct_front.sv @@
// ----------------------------------------------------------------------------
// rdct_front
// Splits the byte stream into tokens, runs the key and value matchers,
// writes token bytes to the store and queues one job per finished token.
// ----------------------------------------------------------------------------
module rdct_front #(
  parameter int unsigned TOKEN_MAX = 32,
  localparam int unsigned IW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1,
  localparam int unsigned LW = $clog2(TOKEN_MAX + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output rdct_pkg::mem_wr_t wr_o,
  output logic [IW-1:0]     wr_idx_o,
  output logic              job_push_o,
  output rdct_pkg::job_t    job_o,
  output logic [LW-1:0]     job_count_o
);

  logic [LW-1:0] length_q, length_d;
  logic          split_q, split_d;
  logic [IW-1:0] split_pos_q, split_pos_d;
  logic          key_hit_q, key_hit_d;
  logic          val_hit_q, val_hit_d;
  logic          ovf_q, ovf_d;
  logic          bank_q, bank_d;
  logic [rdct_pkg::KEY_W-1:0] key_prog_q [rdct_pkg::KEY_PATTERNS];
  logic [rdct_pkg::KEY_W-1:0] key_prog_d [rdct_pkg::KEY_PATTERNS];
  logic [rdct_pkg::VAL_W-1:0] val_prog_q [rdct_pkg::VALUE_PATTERNS];
  logic [rdct_pkg::VAL_W-1:0] val_prog_d [rdct_pkg::VALUE_PATTERNS];
  logic [rdct_pkg::KEY_W-1:0] key_next [rdct_pkg::KEY_PATTERNS];
  logic [rdct_pkg::VAL_W-1:0] val_next [rdct_pkg::VALUE_PATTERNS];
  logic          key_any, val_any;
  logic [7:0]    fold;
  logic          is_sep, is_split;

  assign fold = (in_byte_i >= rdct_pkg::CH_UP_A && in_byte_i <= rdct_pkg::CH_UP_Z) ?
                in_byte_i + rdct_pkg::CASE_OFS : in_byte_i;
  assign is_sep = (in_byte_i == rdct_pkg::CH_SPACE) || (in_byte_i == rdct_pkg::CH_COMMA) ||
                  (in_byte_i == rdct_pkg::CH_SEMI);
  assign is_split = (in_byte_i == rdct_pkg::CH_EQ) || (in_byte_i == rdct_pkg::CH_COLON);

  always_comb begin
    key_any = 1'b0;
    for (int p = 0; p < rdct_pkg::KEY_PATTERNS; p++) begin
      key_next[p] = ((key_prog_q[p] << 1) | rdct_pkg::KEY_W'(1)) & rdct_pkg::key_mask(p, fold);
      key_any     = key_any | key_next[p][rdct_pkg::KEY_LEN[p]-1];
    end
    val_any = 1'b0;
    for (int p = 0; p < rdct_pkg::VALUE_PATTERNS; p++) begin
      val_next[p] = ((val_prog_q[p] << 1) | rdct_pkg::VAL_W'(1)) & rdct_pkg::val_mask(p, fold);
      val_any     = val_any | val_next[p][rdct_pkg::VAL_LEN[p]-1];
    end
  end

  always_comb begin
    length_d    = length_q;
    split_d     = split_q;
    split_pos_d = split_pos_q;
    key_hit_d   = key_hit_q;
    val_hit_d   = val_hit_q;
    ovf_d       = ovf_q;
    bank_d      = bank_q;
    key_prog_d  = key_prog_q;
    val_prog_d  = val_prog_q;
    wr_o.en     = 1'b0;
    wr_o.bank   = bank_q;
    wr_o.data   = in_byte_i;
    wr_idx_o    = length_q[IW-1:0];
    job_push_o  = 1'b0;
    job_o.mode     = rdct_pkg::JM_PLAIN;
    job_o.has_sep  = is_sep;
    job_o.sep_byte = in_byte_i;
    job_o.last     = in_last_i;
    job_o.bank     = bank_q;
    job_count_o    = '0;

    if (accept_i) begin
      if (!is_sep) begin
        if (length_q >= LW'(TOKEN_MAX)) begin
          ovf_d = 1'b1;
        end else begin
          if (!split_q && is_split) begin
            split_d     = 1'b1;
            split_pos_d = length_q[IW-1:0];
            val_hit_d   = 1'b0;
            for (int p = 0; p < rdct_pkg::VALUE_PATTERNS; p++) begin
              val_prog_d[p] = '0;
            end
          end else begin
            if (!split_q) begin
              key_prog_d = key_next;
              key_hit_d  = key_hit_q | key_any;
            end
            val_prog_d = val_next;
            val_hit_d  = val_hit_q | val_any;
          end
          wr_o.en  = 1'b1;
          length_d = length_q + LW'(1);
        end
      end

      if (is_sep || in_last_i) begin
        job_push_o = 1'b1;
        priority if (ovf_d) begin
          job_o.mode = rdct_pkg::JM_OVF;
        end else if (split_d && (key_hit_d || val_hit_d)) begin
          job_o.mode  = rdct_pkg::JM_KEYRED;
          job_count_o = LW'(split_pos_d);
        end else if (!split_d && val_hit_d) begin
          job_o.mode = rdct_pkg::JM_MARK;
        end else begin
          job_o.mode  = rdct_pkg::JM_PLAIN;
          job_count_o = length_d;
        end
        length_d    = '0;
        split_d     = 1'b0;
        split_pos_d = '0;
        key_hit_d   = 1'b0;
        val_hit_d   = 1'b0;
        ovf_d       = 1'b0;
        bank_d      = ~bank_q;
        for (int p = 0; p < rdct_pkg::KEY_PATTERNS; p++) begin
          key_prog_d[p] = '0;
        end
        for (int p = 0; p < rdct_pkg::VALUE_PATTERNS; p++) begin
          val_prog_d[p] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= '0;
      split_q     <= 1'b0;
      split_pos_q <= '0;
      key_hit_q   <= 1'b0;
      val_hit_q   <= 1'b0;
      ovf_q       <= 1'b0;
      bank_q      <= 1'b0;
      for (int p = 0; p < rdct_pkg::KEY_PATTERNS; p++) begin
        key_prog_q[p] <= '0;
      end
      for (int p = 0; p < rdct_pkg::VALUE_PATTERNS; p++) begin
        val_prog_q[p] <= '0;
      end
    end else begin
      length_q    <= length_d;
      split_q     <= split_d;
      split_pos_q <= split_pos_d;
      key_hit_q   <= key_hit_d;
      val_hit_q   <= val_hit_d;
      ovf_q       <= ovf_d;
      bank_q      <= bank_d;
      key_prog_q  <= key_prog_d;
      val_prog_q  <= val_prog_d;
    end
  end

endmodule

@@ src/rdct_jobq.sv @@
// ----------------------------------------------------------------------------
// rdct_jobq
// Two-entry job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module rdct_jobq #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  output logic [1:0]   count_o
);

  logic [W-1:0] ent_q [rdct_pkg::JOBQ_DEPTH];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;
  logic         do_push, do_pop;

  assign do_push = push_i && (count_q != 2'(rdct_pkg::JOBQ_DEPTH));
  assign do_pop  = pop_i && (count_q != 2'd0);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = ent_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ src/rdct_back.sv @@
// ----------------------------------------------------------------------------
// rdct_back
// Holds the two-bank token store and replays each queued job as result
// transactions into a single output register.
// ----------------------------------------------------------------------------
module rdct_back #(
  parameter int unsigned TOKEN_MAX = 32,
  localparam int unsigned IW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1,
  localparam int unsigned LW = $clog2(TOKEN_MAX + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rdct_pkg::mem_wr_t wr_i,
  input  logic [IW-1:0]     wr_idx_i,
  input  logic              job_valid_i,
  input  rdct_pkg::job_t    job_i,
  input  logic [LW-1:0]     job_count_i,
  output logic              job_pop_o,
  output logic              busy_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_byte_o,
  output logic              is_marker_o,
  output logic              run_last_o,
  output logic              string_end_o,
  output logic              token_overflow_o
);

  logic [7:0] store_mem [2][TOKEN_MAX];
  logic [7:0] rd_data_q;

  rdct_pkg::back_state_e state_q, state_d;
  rdct_pkg::job_t        job_q;
  logic [LW-1:0]         count_q;
  logic [IW-1:0]         pos_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_mark_q, out_run_last_q, out_str_end_q, out_ovf_q;

  logic       slot_free, last_byte;
  logic       emit, emit_mark, emit_ovf, emit_final;
  logic [7:0] emit_byte;

  assign slot_free = !out_valid_q || pop_i;
  assign last_byte = ((LW'(pos_q) + LW'(1)) == count_q);
  assign busy_o    = (state_q != rdct_pkg::BK_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdct_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_count_i != '0) ? rdct_pkg::BK_READ :
                    rdct_pkg::after_bytes(job_i.mode, job_i.has_sep);
        end
      end
      rdct_pkg::BK_READ: state_d = rdct_pkg::BK_DATA;
      rdct_pkg::BK_DATA: begin
        if (slot_free) begin
          state_d = last_byte ? rdct_pkg::after_bytes(job_q.mode, job_q.has_sep) :
                    rdct_pkg::BK_READ;
        end
      end
      rdct_pkg::BK_EQ: begin
        if (slot_free) state_d = rdct_pkg::BK_MARK;
      end
      rdct_pkg::BK_MARK: begin
        if (slot_free) state_d = job_q.has_sep ? rdct_pkg::BK_SEP : rdct_pkg::BK_IDLE;
      end
      rdct_pkg::BK_SEP: begin
        if (slot_free) state_d = rdct_pkg::BK_IDLE;
      end
      default: state_d = rdct_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o  = 1'b0;
    emit       = 1'b0;
    emit_byte  = '0;
    emit_mark  = 1'b0;
    emit_ovf   = 1'b0;
    emit_final = 1'b0;
    unique case (state_q)
      rdct_pkg::BK_IDLE: job_pop_o = job_valid_i;
      rdct_pkg::BK_READ: ;
      rdct_pkg::BK_DATA: begin
        emit       = slot_free;
        emit_byte  = rd_data_q;
        emit_final = last_byte &&
                     (rdct_pkg::after_bytes(job_q.mode, job_q.has_sep) == rdct_pkg::BK_IDLE);
      end
      rdct_pkg::BK_EQ: begin
        emit      = slot_free;
        emit_byte = rdct_pkg::CH_EQ;
      end
      rdct_pkg::BK_MARK: begin
        emit       = slot_free;
        emit_mark  = 1'b1;
        emit_ovf   = (job_q.mode == rdct_pkg::JM_OVF);
        emit_final = !job_q.has_sep;
      end
      rdct_pkg::BK_SEP: begin
        emit       = slot_free;
        emit_byte  = job_q.sep_byte;
        emit_final = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_mem[wr_i.bank][wr_idx_i] <= wr_i.data;
    end
    if (state_q == rdct_pkg::BK_READ) begin
      rd_data_q <= store_mem[job_q.bank][pos_q];
    end
    if (job_pop_o) begin
      job_q   <= job_i;
      count_q <= job_count_i;
    end
    if (emit) begin
      out_byte_q     <= emit_byte;
      out_mark_q     <= emit_mark;
      out_ovf_q      <= emit_ovf;
      out_run_last_q <= emit_final;
      out_str_end_q  <= emit_final && job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdct_pkg::BK_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        pos_q <= '0;
      end else if (state_q == rdct_pkg::BK_DATA && slot_free) begin
        pos_q <= pos_q + IW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o          = !out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign is_marker_o      = out_mark_q;
  assign run_last_o       = out_run_last_q;
  assign string_end_o     = out_str_end_q;
  assign token_overflow_o = out_ovf_q;

endmodule

@@ src/token_secret_redactor.sv @@
// ----------------------------------------------------------------------------
// token_secret_redactor
// Token splitter that masks secret values in key/value text.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// input     in         push / full      in_byte_i, in_last_i
// results   out        pop / empty      out_byte_o, is_marker_o, run_last_o,
//                                       string_end_o, token_overflow_o
//
// Bytes inside a token are taken one per cycle while full is low; the matchers
// update in that cycle. A finished token is replayed from the token store: the
// job is taken, then each stored byte passes a store read and the output
// register, followed by '=', marker and separator as the job needs them.
// Two store banks: the front fills one while the back replays the other; full
// is high while one token is replaying and another finished token waits.
// Reset clears all control state; the store needs no clearing.
// ----------------------------------------------------------------------------
module token_secret_redactor #(
  parameter int unsigned TOKEN_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_marker_o,
  output logic       run_last_o,
  output logic       string_end_o,
  output logic       token_overflow_o
);

  localparam int unsigned IW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
  localparam int unsigned LW = $clog2(TOKEN_MAX + 1);
  localparam int unsigned JW = LW + $bits(rdct_pkg::job_t);

  logic              accept;
  rdct_pkg::mem_wr_t wr;
  logic [IW-1:0]     wr_idx;
  logic              job_push, job_pop, job_valid, back_busy;
  rdct_pkg::job_t    job_in, job_out;
  logic [LW-1:0]     cnt_in, cnt_out;
  logic [JW-1:0]     q_data;
  logic [1:0]        q_count;

  assign full   = (q_count == 2'(rdct_pkg::JOBQ_DEPTH)) || (q_count != 2'd0 && back_busy);
  assign accept = push && !full;

  rdct_front #(.TOKEN_MAX(TOKEN_MAX)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .wr_o        (wr),
    .wr_idx_o    (wr_idx),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_count_o (cnt_in)
  );

  rdct_jobq #(.W(JW)) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  ({cnt_in, job_in}),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  assign cnt_out = q_data[JW-1 -: LW];
  assign job_out = q_data[$bits(rdct_pkg::job_t)-1:0];

  rdct_back #(.TOKEN_MAX(TOKEN_MAX)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_i             (wr),
    .wr_idx_i         (wr_idx),
    .job_valid_i      (job_valid),
    .job_i            (job_out),
    .job_count_i      (cnt_out),
    .job_pop_o        (job_pop),
    .busy_o           (back_busy),
    .pop_i            (pop),
    .empty_o          (empty),
    .out_byte_o       (out_byte_o),
    .is_marker_o      (is_marker_o),
    .run_last_o       (run_last_o),
    .string_end_o     (string_end_o),
    .token_overflow_o (token_overflow_o)
  );

endmodule

@@ src/rdct_checker.sv @@
// ----------------------------------------------------------------------------
// rdct_checker
// Port-level checks on the redactor's result transactions.
// ----------------------------------------------------------------------------
module rdct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       is_marker_o,
  input logic       run_last_o,
  input logic       string_end_o,
  input logic       token_overflow_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(is_marker_o) &&
                          $stable(run_last_o) && $stable(string_end_o)))
    else $error("result changed while stalled");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_marker_o) |-> (out_byte_o == 8'h00))
    else $error("marker carries a byte");

  a_ovf_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_overflow_o) |-> is_marker_o)
    else $error("overflow flag without marker");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && string_end_o) |-> run_last_o)
    else $error("string end not on final result of its transaction");

endmodule

bind token_secret_redactor rdct_checker u_checker (.*);

@@ tb/sv/tb_token_secret_redactor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_secret_redactor
// Self-checking bench for the token redactor. Text bytes are queued by a
// stimulus builder and sent by a clocked driver. A byte-level predictor
// tracks token state and pattern matches and queues the expected output
// transactions. A clocked monitor pops them in order and checks every field.
// Both sides stall at random except for one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_token_secret_redactor;

  localparam int TOKEN_MAX  = 32;
  localparam int RAND_BYTES = 93;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC  = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       marker;
    logic       run_last;
    logic       str_end;
    logic       ovf;
  } redact_out_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       push             = 1'b0;
  logic [7:0] in_byte_i        = 8'h00;
  logic       in_last_i        = 1'b0;
  logic       pop              = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic       is_marker_o;
  logic       run_last_o;
  logic       string_end_o;
  logic       token_overflow_o;

  token_secret_redactor #(.TOKEN_MAX(TOKEN_MAX)) dut (
    .clk_i, .rst_ni, .push, .full, .in_byte_i, .in_last_i,
    .empty, .pop, .out_byte_o, .is_marker_o, .run_last_o,
    .string_end_o, .token_overflow_o
  );

  string key_words [rdct_pkg::KEY_PATTERNS] = '{
    "secret", "api_key", "apikey", "api-key", "token", "password",
    "passwd", "credential", "auth", {"private", "_key"}, {"access", "_key"},
    {"session", "_id"}
  };
  string value_words [rdct_pkg::VALUE_PATTERNS] = '{
    "-----begin", "bearer", "sk-", "ghp_", "xox", {"aws", "_secret"}
  };

  // predictor state
  logic [7:0]  tok_store [TOKEN_MAX];
  int          tok_len;
  logic        split_seen;
  int          split_at;
  logic [15:0] key_prog [rdct_pkg::KEY_PATTERNS];
  logic [15:0] val_prog [rdct_pkg::VALUE_PATTERNS];
  logic        key_hit;
  logic        val_hit;
  logic        tok_ovf;

  text_item_t  text_q [$];
  logic [7:0]  tok_buf [$];
  redact_out_t expected_out [$];

  int n_in, n_out, n_redacted, n_overlong, n_strings, err_cnt, idle_cyc;
  logic steady;

  assign steady = (n_in >= 40) && (n_in < 90);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic void clear_token();
    tok_len    = 0;
    split_seen = 1'b0;
    split_at   = 0;
    foreach (key_prog[p]) key_prog[p] = '0;
    foreach (val_prog[p]) val_prog[p] = '0;
    key_hit    = 1'b0;
    val_hit    = 1'b0;
    tok_ovf    = 1'b0;
  endfunction

  function automatic logic [15:0] advance(logic [15:0] prog, string pat, logic [7:0] c);
    logic [15:0] mask;
    mask = '0;
    for (int j = 0; j < pat.len(); j++) begin
      if (pat[j] == c) mask[j] = 1'b1;
    end
    return ((prog << 1) | 16'd1) & mask;
  endfunction

  function automatic void absorb(logic [7:0] b);
    logic [7:0] c;
    c = (b >= rdct_pkg::CH_UP_A && b <= rdct_pkg::CH_UP_Z) ? b + rdct_pkg::CASE_OFS : b;
    if (tok_len >= TOKEN_MAX) begin
      tok_ovf = 1'b1;
      return;
    end
    if (!split_seen && (b == rdct_pkg::CH_EQ || b == rdct_pkg::CH_COLON)) begin
      split_seen = 1'b1;
      split_at   = tok_len;
      foreach (val_prog[p]) val_prog[p] = '0;
      val_hit    = 1'b0;
    end else begin
      if (!split_seen) begin
        foreach (key_prog[p]) begin
          key_prog[p] = advance(key_prog[p], key_words[p], c);
          if (key_prog[p][key_words[p].len()-1]) key_hit = 1'b1;
        end
      end
      foreach (val_prog[p]) begin
        val_prog[p] = advance(val_prog[p], value_words[p], c);
        if (val_prog[p][value_words[p].len()-1]) val_hit = 1'b1;
      end
    end
    tok_store[tok_len] = b;
    tok_len++;
  endfunction

  function automatic redact_out_t mk(logic [7:0] data, logic marker, logic ovf);
    redact_out_t r;
    r.data     = marker ? 8'h00 : data;
    r.marker   = marker;
    r.run_last = 1'b0;
    r.str_end  = 1'b0;
    r.ovf      = ovf;
    return r;
  endfunction

  function automatic void redact_byte(logic [7:0] b, logic last);
    redact_out_t r;
    logic        is_sep;
    is_sep = (b == rdct_pkg::CH_SPACE) || (b == rdct_pkg::CH_COMMA) ||
             (b == rdct_pkg::CH_SEMI);
    if (!is_sep) absorb(b);
    if (!is_sep && !last) return;
    if (tok_ovf) begin
      expected_out.push_back(mk(8'h00, 1'b1, 1'b1));
      n_overlong++;
    end else if (split_seen && (key_hit || val_hit)) begin
      for (int i = 0; i < split_at; i++) expected_out.push_back(mk(tok_store[i], 1'b0, 1'b0));
      expected_out.push_back(mk(rdct_pkg::CH_EQ, 1'b0, 1'b0));
      expected_out.push_back(mk(8'h00, 1'b1, 1'b0));
      n_redacted++;
    end else if (!split_seen && val_hit) begin
      expected_out.push_back(mk(8'h00, 1'b1, 1'b0));
      n_redacted++;
    end else begin
      for (int i = 0; i < tok_len; i++) expected_out.push_back(mk(tok_store[i], 1'b0, 1'b0));
    end
    if (is_sep) expected_out.push_back(mk(b, 1'b0, 1'b0));
    clear_token();
    r = expected_out.pop_back();
    r.run_last = 1'b1;
    r.str_end  = last;
    expected_out.push_back(r);
    if (last) n_strings++;
  endfunction

  // ---------------- stimulus ----------------
  function automatic void queue_raw(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back('{s[i], 1'b0});
  endfunction

  function automatic logic [7:0] mix_case(logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7A && $urandom_range(0, 1) == 1) return b - rdct_pkg::CASE_OFS;
    return b;
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) tok_buf.push_back(mix_case(s[i]));
  endfunction

  function automatic void append_letters(int n);
    string alphabet;
    alphabet = "abcdefghijklmnopqrstuvwxyz0123456789_-";
    for (int i = 0; i < n; i++) begin
      tok_buf.push_back(mix_case(alphabet[$urandom_range(0, alphabet.len()-1)]));
    end
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 2))
      0:       return rdct_pkg::CH_SPACE;
      1:       return rdct_pkg::CH_COMMA;
      default: return rdct_pkg::CH_SEMI;
    endcase
  endfunction

  function automatic void flush_token(logic force_sep);
    int n;
    n = tok_buf.size();
    if (!force_sep && n > 0 && $urandom_range(0, 7) == 0) begin
      for (int i = 0; i < n; i++) text_q.push_back('{tok_buf[i], i == n - 1});
    end else begin
      for (int i = 0; i < n; i++) text_q.push_back('{tok_buf[i], 1'b0});
      text_q.push_back('{pick_sep(), $urandom_range(0, 4) == 0});
    end
    tok_buf.delete();
  endfunction

  function automatic void gen_token();
    string w;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        append_letters($urandom_range(0, 2));
        append_text(key_words[$urandom_range(0, rdct_pkg::KEY_PATTERNS-1)]);
        tok_buf.push_back($urandom_range(0, 1) ? rdct_pkg::CH_EQ : rdct_pkg::CH_COLON);
        append_letters($urandom_range(0, 5));
      end
      3, 4: begin
        if ($urandom_range(0, 1) == 1) begin
          append_letters($urandom_range(0, 3));
          tok_buf.push_back($urandom_range(0, 1) ? rdct_pkg::CH_EQ : rdct_pkg::CH_COLON);
        end
        append_text(value_words[$urandom_range(0, rdct_pkg::VALUE_PATTERNS-1)]);
        append_letters($urandom_range(0, 3));
      end
      5: begin
        w = key_words[$urandom_range(0, rdct_pkg::KEY_PATTERNS-1)];
        append_text(w.substr(0, w.len() - 2));
        tok_buf.push_back(rdct_pkg::CH_EQ);
        append_letters($urandom_range(1, 4));
      end
      6, 7: begin
        append_letters($urandom_range(1, 6));
        if ($urandom_range(0, 2) == 0) tok_buf.push_back(rdct_pkg::CH_EQ);
        append_letters($urandom_range(0, 3));
      end
      8: begin
        repeat ($urandom_range(1, 6)) tok_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        if ($urandom_range(0, 2) == 0) append_letters($urandom_range(TOKEN_MAX + 1, TOKEN_MAX + 8));
      end
    endcase
    flush_token(1'b0);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        redact_byte(in_byte_i, in_last_i);
        n_in++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (text_q.size() > 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        push      <= 1'b1;
        in_byte_i <= text_q[0].data;
        in_last_i <= text_q[0].last;
        void'(text_q.pop_front());
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic report(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    redact_out_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        n_out++;
        if (expected_out.size() == 0) begin
          report("unexpected transaction, out_byte", out_byte_o, 0);
        end else begin
          e = expected_out.pop_front();
          if (out_byte_o !== e.data)         report("out_byte", out_byte_o, e.data);
          if (is_marker_o !== e.marker)      report("is_marker", is_marker_o, e.marker);
          if (run_last_o !== e.run_last)     report("run_last", run_last_o, e.run_last);
          if (string_end_o !== e.str_end)    report("string_end", string_end_o, e.str_end);
          if (token_overflow_o !== e.ovf)    report("token_overflow", token_overflow_o, e.ovf);
        end
      end
      pop <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int directed;
    n_in = 0; n_out = 0; n_redacted = 0; n_overlong = 0; n_strings = 0;
    err_cnt = 0; idle_cyc = 0;
    clear_token();

    // key hit with ':' split, bare value marker, value hit after split,
    // empty token, high byte ending a string, zero byte then separator end
    queue_raw("TOKEN:v,");
    queue_raw("sK-;");
    queue_raw("a=Bearer:z ");
    text_q.push_back('{rdct_pkg::CH_COMMA, 1'b0});
    text_q.push_back('{8'hFF, 1'b1});
    text_q.push_back('{8'h00, 1'b0});
    text_q.push_back('{rdct_pkg::CH_SEMI, 1'b1});
    directed = text_q.size();

    // buffer exactly full, then one byte past it
    append_letters(TOKEN_MAX);
    flush_token(1'b1);
    append_letters(TOKEN_MAX + 1);
    flush_token(1'b1);
    while (text_q.size() < directed + RAND_BYTES) gen_token();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || push || expected_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d output transactions.",
             n_in, n_strings, n_out);
    $display("Tokens masked: %0d, overlong tokens replaced: %0d.", n_redacted, n_overlong);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rdct_pkg.sv
src/rdct_front.sv
src/rdct_jobq.sv
src/rdct_back.sv
src/token_secret_redactor.sv
src/rdct_checker.sv
tb/sv/tb_token_secret_redactor.sv
